[src/hrpf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrpf_pkg
// Types, constants and helpers shared by the regime probability filter.
// ----------------------------------------------------------------------------
package hrpf_pkg;

  localparam int VAL_W   = 32;
  localparam int PROB_W  = 33;
  localparam int DENS_W  = 48;
  localparam int DIV_NW  = 84;
  localparam int DIV_DW  = 52;
  localparam int DIV_QW  = 49;
  localparam int DIV_CW  = 7;
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int FIFO_DEPTH = 2;

  localparam logic [2:0] CFG_FILTER_MODE    = 3'd0;
  localparam logic [2:0] CFG_STAY_PROB_LOW  = 3'd1;
  localparam logic [2:0] CFG_STAY_PROB_HIGH = 3'd2;
  localparam logic [2:0] CFG_EXTRA_DRIFT    = 3'd3;
  localparam logic [2:0] CFG_SD_FIRST       = 3'd4;
  localparam logic [2:0] CFG_SD_SECOND      = 3'd5;

  localparam logic [1:0] MODE_OWN_SD  = 2'd0;
  localparam logic [1:0] MODE_PICK_SD = 2'd1;
  localparam logic [1:0] MODE_PICK_DR = 2'd2;

  localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
  localparam logic [17:0] SQRT2PI_Q16 = 18'd164274;
  localparam logic [23:0] EXP_C1      = 24'd11629080;
  localparam logic [23:0] EXP_C2      = 24'd3240472;
  localparam logic [DENS_W-1:0] DENS_FLOOR = 48'd110;
  localparam logic [DIV_QW-1:0] DENS_MAX   = 49'h0_FFFF_FFFF_FFFF;
  localparam logic [DIV_QW-1:0] Z_CAP      = 49'd1048576;
  localparam logic [PROB_W-1:0] PONE       = 33'h1_0000_0000;
  // 1e-10 in Q1.32 truncates to zero, so the floor is one LSB.
  localparam logic [PROB_W-1:0] PROB_FLOOR = 33'd1;
  localparam logic [DIV_CW-1:0] Z_STEPS    = 7'd21;
  localparam logic [DIV_CW-1:0] DENS_STEPS = 7'd48;
  localparam logic [DIV_CW-1:0] PROB_STEPS = 7'd33;

  typedef struct packed {
    logic [1:0]         filter_mode;
    logic [31:0]        stay_prob_low;
    logic [31:0]        stay_prob_high;
    logic signed [31:0] extra_drift;
    logic [31:0]        sd_first;
    logic [31:0]        sd_second;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] level;
    logic signed [31:0] base_drift;
    logic               regime_bit;
    logic               first_item;
  } in_item_t;

  typedef struct packed {
    logic [PROB_W-1:0] prob_regime_low;
    logic [PROB_W-1:0] prob_regime_high;
    logic              density_floored;
  } out_item_t;

  typedef struct packed {
    logic        first_item;
    logic        use_raw;
    logic [31:0] mag0;
    logic [31:0] mag1;
    logic [31:0] sd0;
    logic [31:0] sd1;
  } work_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
    logic [DIV_CW-1:0] steps;
    logic [DIV_QW-1:0] cap;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat_val(input logic signed [34:0] x);
    logic signed [31:0] r;
    if (x > 35'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -35'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag_of(input logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [PROB_W-1:0] floored(input logic [PROB_W-1:0] v);
    return (v < PROB_FLOOR) ? PROB_FLOOR : v;
  endfunction

endpackage
`default_nettype wire

[src/hrpf_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrpf_fifo
// Short work queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module hrpf_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  hrpf_pkg::work_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output hrpf_pkg::work_t rd_data,
  output logic           empty
);
  import hrpf_pkg::*;

  work_t      mem_r [FIFO_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'(FIFO_DEPTH));
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

[src/hrpf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrpf_front
// Accepts items, forms the regime residuals and picks the deviations.
// ----------------------------------------------------------------------------
module hrpf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  hrpf_pkg::in_item_t in_data,
  output logic               in_full,
  input  hrpf_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               q_wr,
  output hrpf_pkg::work_t    q_data
);
  import hrpf_pkg::*;

  logic signed [31:0] prev_level_r;
  logic signed [34:0] v;
  logic signed [34:0] vn;
  logic signed [31:0] r0;
  logic signed [31:0] r1;
  logic [31:0]        sd_a;
  logic [31:0]        sd_b;
  logic [31:0]        sd_pick;

  assign in_full = q_full;
  assign q_wr    = in_push && !q_full;

  always_comb begin
    v       = 35'(in_data.level) - 35'(prev_level_r) - 35'(in_data.base_drift);
    vn      = v - 35'(cfg.extra_drift);
    sd_a    = (cfg.sd_first == 32'd0) ? 32'd1 : cfg.sd_first;
    sd_b    = (cfg.sd_second == 32'd0) ? 32'd1 : cfg.sd_second;
    sd_pick = in_data.regime_bit ? sd_b : sd_a;
    q_data.first_item = in_data.first_item;
    q_data.use_raw    = 1'b0;
    r0 = sat_val(v);
    r1 = sat_val(vn);
    q_data.sd0 = sd_a;
    q_data.sd1 = sd_b;
    case (cfg.filter_mode)
      MODE_PICK_SD: begin
        q_data.use_raw = 1'b1;
        q_data.sd0     = sd_pick;
        q_data.sd1     = sd_pick;
      end
      MODE_PICK_DR: begin
        q_data.use_raw = 1'b1;
        r0 = in_data.regime_bit ? sat_val(vn) : sat_val(v);
        r1 = r0;
      end
      default: begin
        q_data.use_raw = 1'b0;
      end
    endcase
    q_data.mag0 = mag_of(r0);
    q_data.mag1 = mag_of(r1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r <= '0;
    end else if (q_wr) begin
      prev_level_r <= in_data.level;
    end
  end

endmodule
`default_nettype wire

[src/hrpf_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrpf_div
// Restoring divider, one quotient bit per cycle, with a saturating cap.
// ----------------------------------------------------------------------------
module hrpf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  hrpf_pkg::div_req_t req,
  output hrpf_pkg::div_rsp_t rsp
);
  import hrpf_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_NW-1:0] num_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_QW-1:0] quo_r;
  logic [DIV_QW-1:0] cap_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] hi;
  logic [DIV_DW:0]   rs;
  logic              ge;
  logic [DIV_DW:0]   rem_n;
  logic [DIV_QW-1:0] quo_n;

  always_comb begin
    hi    = req.num >> req.steps;
    rs    = {rem_r, num_r[cnt_r]};
    ge    = rs >= {1'b0, den_r};
    rem_n = ge ? (rs - {1'b0, den_r}) : rs;
    quo_n = {quo_r[DIV_QW-2:0], ge};
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.den == '0 || hi >= DIV_NW'(req.den)) begin
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      cap_r <= req.cap;
      cnt_r <= req.steps - DIV_CW'(1);
      rem_r <= hi[DIV_DW-1:0];
      quo_r <= (req.den == '0 || hi >= DIV_NW'(req.den)) ? req.cap : '0;
    end else if (busy_r) begin
      rem_r <= rem_n[DIV_DW-1:0];
      cnt_r <= cnt_r - DIV_CW'(1);
      if (cnt_r == '0) begin
        quo_r <= (quo_n > cap_r) ? cap_r : quo_n;
      end else begin
        quo_r <= quo_n;
      end
    end
  end

endmodule
`default_nettype wire

[src/hrpf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrpf_back
// Sequencer: densities, transition weighting, normalization and result.
// ----------------------------------------------------------------------------
module hrpf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hrpf_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  hrpf_pkg::work_t     q_data,
  output logic                q_rd,
  output hrpf_pkg::div_req_t  div_req,
  input  hrpf_pkg::div_rsp_t  div_rsp,
  input  logic                out_pop,
  output logic                out_empty,
  output hrpf_pkg::out_item_t out_data
);
  import hrpf_pkg::*;

  typedef enum logic [24:0] {
    ST_IDLE = 25'd1 << 0,
    ST_ZS   = 25'd1 << 1,
    ST_ZW   = 25'd1 << 2,
    ST_M1   = 25'd1 << 3,
    ST_M2   = 25'd1 << 4,
    ST_M3   = 25'd1 << 5,
    ST_M4   = 25'd1 << 6,
    ST_M5   = 25'd1 << 7,
    ST_M6   = 25'd1 << 8,
    ST_M7   = 25'd1 << 9,
    ST_DW   = 25'd1 << 10,
    ST_W0   = 25'd1 << 11,
    ST_W1   = 25'd1 << 12,
    ST_W2   = 25'd1 << 13,
    ST_W3   = 25'd1 << 14,
    ST_W4   = 25'd1 << 15,
    ST_T1   = 25'd1 << 16,
    ST_T2   = 25'd1 << 17,
    ST_T3   = 25'd1 << 18,
    ST_T4   = 25'd1 << 19,
    ST_MIX  = 25'd1 << 20,
    ST_P0   = 25'd1 << 21,
    ST_PW0  = 25'd1 << 22,
    ST_PW1  = 25'd1 << 23,
    ST_OUT  = 25'd1 << 24
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  work_t             wk_r;
  logic              idx_r;
  logic [20:0]       z_r;
  logic [8:0]        k_r;
  logic [23:0]       g_r;
  logic [23:0]       t1e_r;
  logic [24:0]       e_r;
  logic [DENS_W-1:0] d0_r;
  logic [DENS_W-1:0] d1_r;
  logic [33:0]       wacc_r;
  logic [33:0]       w0_r;
  logic [33:0]       w1_r;
  logic [57:0]       tacc_r;
  logic [50:0]       t0_r;
  logic [50:0]       t1_r;
  logic [50:0]       num0_r;
  logic [50:0]       num1_r;
  logic [DIV_DW-1:0] den_r;
  logic              flag_r;
  logic [PROB_W-1:0] lo_r;
  logic [PROB_W-1:0] raw_lo_r;
  logic [PROB_W-1:0] raw_hi_r;
  logic              res_valid_r;
  out_item_t         res_r;
  logic [PROD_W-1:0] prod_r;

  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROB_W-1:0] q_s;
  logic [PROB_W-1:0] p_s;
  logic [PROB_W-1:0] p0;
  logic [PROB_W-1:0] p1;
  logic [31:0]       sd_i;
  logic [31:0]       mag_i;
  logic [25:0]       m_val;
  logic [82:0]       t_full;
  logic [51:0]       mix;
  logic [DENS_W-1:0] d_new;
  logic              res_free;

  assign q_s      = PROB_W'(cfg.stay_prob_low);
  assign p_s      = PROB_W'(cfg.stay_prob_high);
  assign p0       = wk_r.use_raw ? raw_lo_r : floored(raw_lo_r);
  assign p1       = wk_r.use_raw ? raw_hi_r : floored(raw_hi_r);
  assign sd_i     = idx_r ? wk_r.sd1 : wk_r.sd0;
  assign mag_i    = idx_r ? wk_r.mag1 : wk_r.mag0;
  assign m_val    = 26'd16777216 - 26'(t1e_r) + 26'(prod_r[47:24]);
  assign t_full   = {1'b0, prod_r[57:0], 24'd0} + 83'(tacc_r);
  assign mix      = 52'(t0_r) + 52'(t1_r);
  assign d_new    = (div_rsp.quo[DENS_W-1:0] < DENS_FLOOR) ? DENS_FLOOR
                                                           : div_rsp.quo[DENS_W-1:0];
  assign res_free = !res_valid_r || out_pop;
  assign q_rd     = (state_r == ST_IDLE) && !q_empty;

  assign out_empty = !res_valid_r;
  assign out_data  = res_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_M1: begin
        mul_a = MUL_W'(z_r);
        mul_b = MUL_W'(z_r);
      end
      ST_M2: begin
        mul_a = MUL_W'(prod_r[41:9]);
        mul_b = MUL_W'(LOG2E_Q30);
      end
      ST_M3: begin
        mul_a = MUL_W'(prod_r[53:30]);
        mul_b = MUL_W'(EXP_C1);
      end
      ST_M4: begin
        mul_a = MUL_W'(g_r);
        mul_b = MUL_W'(g_r);
      end
      ST_M5: begin
        mul_a = MUL_W'(prod_r[47:24]);
        mul_b = MUL_W'(EXP_C2);
      end
      ST_M6: begin
        mul_a = MUL_W'(sd_i);
        mul_b = MUL_W'(SQRT2PI_Q16);
      end
      ST_W0: begin
        mul_a = MUL_W'(q_s);
        mul_b = MUL_W'(p0);
      end
      ST_W1: begin
        mul_a = MUL_W'(PONE - p_s);
        mul_b = MUL_W'(p1);
      end
      ST_W2: begin
        mul_a = MUL_W'(PONE - q_s);
        mul_b = MUL_W'(p0);
      end
      ST_W3: begin
        mul_a = MUL_W'(p_s);
        mul_b = MUL_W'(p1);
      end
      ST_W4: begin
        mul_a = w0_r;
        mul_b = MUL_W'(d0_r[23:0]);
      end
      ST_T1: begin
        mul_a = w0_r;
        mul_b = MUL_W'(d0_r[47:24]);
      end
      ST_T2: begin
        mul_a = w1_r;
        mul_b = MUL_W'(d1_r[23:0]);
      end
      ST_T3: begin
        mul_a = w1_r;
        mul_b = MUL_W'(d1_r[47:24]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = DIV_NW'({num0_r, 32'd0});
    div_req.den   = den_r;
    div_req.steps = PROB_STEPS;
    div_req.cap   = DIV_QW'(PONE);
    case (state_r)
      ST_ZS: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'({mag_i, 16'd0});
        div_req.den   = DIV_DW'(sd_i);
        div_req.steps = Z_STEPS;
        div_req.cap   = Z_CAP;
      end
      ST_M7: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'({e_r, 48'd0});
        div_req.den   = prod_r[DIV_DW-1:0];
        div_req.steps = DENS_STEPS;
        div_req.cap   = DENS_MAX;
      end
      ST_P0: begin
        div_req.start = 1'b1;
      end
      ST_PW0: begin
        div_req.start = div_rsp.done;
        div_req.num   = DIV_NW'({num1_r, 32'd0});
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_data.first_item ? ST_P0 : ST_ZS;
        end
      end
      ST_ZS:  state_nxt = ST_ZW;
      ST_ZW:  state_nxt = div_rsp.done ? ST_M1 : ST_ZW;
      ST_M1:  state_nxt = ST_M2;
      ST_M2:  state_nxt = ST_M3;
      ST_M3:  state_nxt = ST_M4;
      ST_M4:  state_nxt = ST_M5;
      ST_M5:  state_nxt = ST_M6;
      ST_M6:  state_nxt = ST_M7;
      ST_M7:  state_nxt = ST_DW;
      ST_DW: begin
        if (div_rsp.done) begin
          state_nxt = idx_r ? ST_W0 : ST_ZS;
        end
      end
      ST_W0:  state_nxt = ST_W1;
      ST_W1:  state_nxt = ST_W2;
      ST_W2:  state_nxt = ST_W3;
      ST_W3:  state_nxt = ST_W4;
      ST_W4:  state_nxt = ST_T1;
      ST_T1:  state_nxt = ST_T2;
      ST_T2:  state_nxt = ST_T3;
      ST_T3:  state_nxt = ST_T4;
      ST_T4:  state_nxt = ST_MIX;
      ST_MIX: state_nxt = ST_P0;
      ST_P0:  state_nxt = ST_PW0;
      ST_PW0: state_nxt = div_rsp.done ? ST_PW1 : ST_PW0;
      ST_PW1: state_nxt = div_rsp.done ? ST_OUT : ST_PW1;
      ST_OUT: state_nxt = res_free ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
      raw_lo_r    <= '0;
      raw_hi_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_PW1 && div_rsp.done) begin
        raw_lo_r <= lo_r;
        raw_hi_r <= div_rsp.quo[PROB_W-1:0];
      end
      if (state_r == ST_OUT && res_free) begin
        res_valid_r <= 1'b1;
      end else if (out_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        wk_r   <= q_data;
        idx_r  <= 1'b0;
        flag_r <= 1'b0;
        num0_r <= 51'(PONE - p_s);
        num1_r <= 51'(PONE - q_s);
        den_r  <= DIV_DW'(PONE - p_s) + DIV_DW'(PONE - q_s);
      end
      ST_ZW: begin
        z_r <= div_rsp.quo[20:0];
      end
      ST_M3: begin
        k_r <= prod_r[62:54];
        g_r <= prod_r[53:30];
      end
      ST_M4: begin
        t1e_r <= prod_r[47:24];
      end
      ST_M6: begin
        e_r <= (k_r >= 9'd25) ? 25'd0 : 25'(m_val >> k_r[4:0]);
      end
      ST_DW: begin
        if (div_rsp.done) begin
          if (idx_r) begin
            d1_r <= d_new;
          end else begin
            d0_r <= d_new;
          end
          idx_r <= 1'b1;
        end
      end
      ST_W1: wacc_r <= prod_r[65:32];
      ST_W2: w0_r   <= wacc_r + prod_r[65:32];
      ST_W3: wacc_r <= prod_r[65:32];
      ST_W4: w1_r   <= wacc_r + prod_r[65:32];
      ST_T1: tacc_r <= prod_r[57:0];
      ST_T2: t0_r   <= t_full[82:32];
      ST_T3: tacc_r <= prod_r[57:0];
      ST_T4: t1_r   <= t_full[82:32];
      ST_MIX: begin
        num0_r <= t0_r;
        num1_r <= t1_r;
        if (mix < 52'(DENS_FLOOR)) begin
          den_r  <= 52'(DENS_FLOOR);
          flag_r <= 1'b1;
        end else begin
          den_r <= mix;
        end
      end
      ST_PW0: begin
        if (div_rsp.done) begin
          lo_r <= div_rsp.quo[PROB_W-1:0];
        end
      end
      ST_OUT: begin
        if (res_free) begin
          res_r.prob_regime_low  <= floored(raw_lo_r);
          res_r.prob_regime_high <= floored(raw_hi_r);
          res_r.density_floored  <= flag_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[src/hamilton_regime_probability_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hamilton_regime_probability_filter
// Two-state regime filter: ergodic start, Gaussian densities, normalization.
//
//   channel | ports                                     | transfer when
//   input   | in_push, in_full, in_data                 | in_push && !in_full
//   result  | out_pop, out_empty, out_data              | out_pop && !out_empty
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// The sequencer waits on the bit-serial divider that serves the two deviation
// scalings, the two density scalings and the two normalizations. A first item
// needs only the normalizations; a division that saturates at once ends early.
// The front end keeps taking items into a two-entry queue while the sequencer
// works, and the sequencer runs on while one result waits. Reset is
// synchronous and needs no sweep.
// ----------------------------------------------------------------------------
module hamilton_regime_probability_filter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  hrpf_pkg::in_item_t  in_data,
  input  logic                out_pop,
  output logic                out_empty,
  output hrpf_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import hrpf_pkg::*;

  cfg_t     cfg_r;
  work_t    fw_data;
  logic     fw_wr;
  logic     q_full;
  logic     q_empty;
  logic     q_rd;
  work_t    q_data;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_mode    <= MODE_OWN_SD;
      cfg_r.stay_prob_low  <= 32'd3865470566;
      cfg_r.stay_prob_high <= 32'd3865470566;
      cfg_r.extra_drift    <= '0;
      cfg_r.sd_first       <= 32'd65536;
      cfg_r.sd_second      <= 32'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FILTER_MODE:    cfg_r.filter_mode    <= cfg_data[1:0];
        CFG_STAY_PROB_LOW:  cfg_r.stay_prob_low  <= cfg_data;
        CFG_STAY_PROB_HIGH: cfg_r.stay_prob_high <= cfg_data;
        CFG_EXTRA_DRIFT:    cfg_r.extra_drift    <= cfg_data;
        CFG_SD_FIRST:       cfg_r.sd_first       <= cfg_data;
        CFG_SD_SECOND:      cfg_r.sd_second      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  hrpf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_wr    (fw_wr),
    .q_data  (fw_data)
  );

  hrpf_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fw_wr),
    .wr_data (fw_data),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  hrpf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  hrpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_rd      (q_rd),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
